// ===== rtl/core/fconv_pkg.sv =====
package fconv_pkg;

    localparam int MAX_TAPS     = 64;
    localparam int MAX_SAMPLES  = 64;
    localparam int SAMPLE_WIDTH = 16;

    localparam int TAP_AW     = 6;
    localparam int SMP_AW     = $clog2(MAX_SAMPLES);
    localparam int CNT_W      = $clog2(MAX_SAMPLES + 1);
    localparam int TC_W       = 7;
    localparam int OFF_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int RES_W      = 32;
    localparam int PROD_W     = 2 * SAMPLE_WIDTH;
    localparam int ACC_W      = PROD_W + TC_W;
    localparam int POS_W      = CNT_W + 1;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAP_COUNT  = 2'd0,
        CFG_TAP_OFFSET = 2'd1,
        CFG_CIRCULAR   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [TC_W-1:0]  tap_count;
        logic [OFF_W-1:0] tap_offset;
        logic             circular;
    } t_cfg;

    typedef struct packed {
        logic                    wr_tap;
        logic                    wr_smp;
        logic                    close;
        logic [TAP_AW-1:0]       tap_addr;
        logic [SMP_AW-1:0]       smp_addr;
        logic [SAMPLE_WIDTH-1:0] value;
        logic [CNT_W-1:0]        len;
    } t_cmd;

    typedef struct packed {
        logic [RES_W-1:0] result;
        logic             last;
    } t_res;

endpackage

// ===== rtl/core/fconv_front.sv =====
module fconv_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  logic                               i_full,
    input  logic                               i_mode,
    input  logic [fconv_pkg::TAP_AW-1:0]       i_tap_index,
    input  logic [fconv_pkg::SAMPLE_WIDTH-1:0] i_value,
    input  logic                               i_last,
    output logic                               o_cmd_push,
    output fconv_pkg::t_cmd                    o_cmd
);

    logic [fconv_pkg::CNT_W-1:0] r_count;
    logic [fconv_pkg::CNT_W-1:0] n_count;
    logic                        room;
    logic                        accept;

    assign accept = i_push && !i_full;
    assign room   = (32'(r_count) < fconv_pkg::MAX_SAMPLES);

    always_comb begin
        o_cmd          = '0;
        o_cmd.value    = i_value;
        o_cmd.tap_addr = i_tap_index;
        o_cmd.smp_addr = r_count[fconv_pkg::SMP_AW-1:0];
        n_count        = r_count;
        if (!i_mode) begin
            o_cmd.wr_tap = (32'(i_tap_index) < fconv_pkg::MAX_TAPS);
        end else begin
            o_cmd.wr_smp = room;
            if (room) begin
                n_count = r_count + fconv_pkg::CNT_W'(1);
            end
            if (i_last) begin
                o_cmd.close = 1'b1;
                o_cmd.len   = n_count;
                n_count     = '0;
            end
        end
    end

    assign o_cmd_push = accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept) begin
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/core/fconv_cmd_fifo.sv =====
module fconv_cmd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  fconv_pkg::t_cmd i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_vld,
    output fconv_pkg::t_cmd o_data
);

    fconv_pkg::t_cmd             r_mem [fconv_pkg::Q_DEPTH];
    logic [fconv_pkg::Q_AW-1:0]  r_wr;
    logic [fconv_pkg::Q_AW-1:0]  r_rd;
    logic [fconv_pkg::Q_CW-1:0]  r_cnt;
    logic                        do_push;
    logic                        do_pop;

    assign o_full  = (32'(r_cnt) == fconv_pkg::Q_DEPTH);
    assign o_vld   = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + fconv_pkg::Q_AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + fconv_pkg::Q_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + fconv_pkg::Q_CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - fconv_pkg::Q_CW'(1);
            end
        end
    end

endmodule

// ===== rtl/core/fconv_out_fifo.sv =====
module fconv_out_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  fconv_pkg::t_res i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output fconv_pkg::t_res o_data
);

    fconv_pkg::t_res             r_mem [fconv_pkg::Q_DEPTH];
    logic [fconv_pkg::Q_AW-1:0]  r_wr;
    logic [fconv_pkg::Q_AW-1:0]  r_rd;
    logic [fconv_pkg::Q_CW-1:0]  r_cnt;
    logic                        do_push;
    logic                        do_pop;

    assign o_full  = (32'(r_cnt) == fconv_pkg::Q_DEPTH);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + fconv_pkg::Q_AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + fconv_pkg::Q_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + fconv_pkg::Q_CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - fconv_pkg::Q_CW'(1);
            end
        end
    end

endmodule

// ===== rtl/core/fconv_back.sv =====
module fconv_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fconv_pkg::t_cfg i_cfg,
    input  logic            i_cmd_vld,
    input  fconv_pkg::t_cmd i_cmd,
    output logic            o_cmd_pop,
    input  logic            i_res_full,
    output logic            o_res_push,
    output fconv_pkg::t_res o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_START,
        S_ISSUE,
        S_DRAIN,
        S_WRITE
    } t_state;

    localparam int SH = fconv_pkg::SAMPLE_WIDTH - 1;
    localparam int SW = fconv_pkg::ACC_W - SH;

    logic [fconv_pkg::SAMPLE_WIDTH-1:0] r_taps [fconv_pkg::MAX_TAPS];
    logic [fconv_pkg::SAMPLE_WIDTH-1:0] r_smps [fconv_pkg::MAX_SAMPLES];

    t_state                              r_state;
    logic [fconv_pkg::CNT_W-1:0]         r_n;
    logic [fconv_pkg::CNT_W-1:0]         r_base;
    logic [fconv_pkg::SMP_AW-1:0]        r_i;
    logic [fconv_pkg::TC_W-1:0]          r_k;
    logic [fconv_pkg::SMP_AW-1:0]        r_xc;
    logic signed [fconv_pkg::POS_W-1:0]  r_xz;
    logic signed [fconv_pkg::ACC_W-1:0]  r_acc;
    logic                                r_p1_vld;
    logic                                r_p1_use;
    logic                                r_p2_vld;
    logic [fconv_pkg::SAMPLE_WIDTH-1:0]  r_tap_q;
    logic [fconv_pkg::SAMPLE_WIDTH-1:0]  r_smp_q;
    logic signed [fconv_pkg::PROD_W-1:0] r_prod;

    logic [fconv_pkg::TC_W-1:0]    tc;
    logic                          cmd_take;
    logic                          use_tap;
    logic [fconv_pkg::SMP_AW-1:0]  smp_rd;
    logic [fconv_pkg::TAP_AW-1:0]  tap_rd;
    logic                          is_last;
    logic signed [SW-1:0]          shifted;

    assign tc = (32'(i_cfg.tap_count) > fconv_pkg::MAX_TAPS)
              ? fconv_pkg::TC_W'(fconv_pkg::MAX_TAPS) : i_cfg.tap_count;

    assign cmd_take  = (r_state == S_IDLE) && i_cmd_vld;
    assign o_cmd_pop = cmd_take;

    assign use_tap = i_cfg.circular ||
                     (!r_xz[fconv_pkg::POS_W-1] &&
                      (r_xz[fconv_pkg::CNT_W-1:0] < r_n));
    assign smp_rd  = i_cfg.circular ? r_xc : r_xz[fconv_pkg::SMP_AW-1:0];
    assign tap_rd  = r_k[fconv_pkg::TAP_AW-1:0];
    assign is_last = ((fconv_pkg::CNT_W'(r_i) + fconv_pkg::CNT_W'(1)) == r_n);

    // the shifted sum of at most MAX_TAPS full-scale products always fits the result
    assign shifted = SW'(r_acc >>> SH);

    always_comb begin
        o_res.last   = is_last;
        o_res.result = {{(fconv_pkg::RES_W-SW){shifted[SW-1]}}, shifted};
    end

    assign o_res_push = (r_state == S_WRITE) && !i_res_full;

    // kernel and frame storage
    always_ff @(posedge i_clk) begin
        if (cmd_take && i_cmd.wr_tap) begin
            r_taps[i_cmd.tap_addr] <= i_cmd.value;
        end
        if (cmd_take && i_cmd.wr_smp) begin
            r_smps[i_cmd.smp_addr] <= i_cmd.value;
        end
        r_tap_q <= r_taps[tap_rd];
        r_smp_q <= r_smps[smp_rd];
    end

    always_ff @(posedge i_clk) begin
        r_p1_use <= use_tap;
        if (r_p1_use) begin
            r_prod <= $signed(r_tap_q) * $signed(r_smp_q);
        end else begin
            r_prod <= '0;
        end
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
        end else begin
            r_p1_vld <= (r_state == S_ISSUE);
            r_p2_vld <= r_p1_vld;
            if (r_p2_vld) begin
                r_acc <= r_acc + fconv_pkg::ACC_W'(r_prod);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (cmd_take && i_cmd.close) begin
                        r_n     <= i_cmd.len;
                        r_base  <= fconv_pkg::CNT_W'(i_cfg.tap_offset);
                        r_i     <= '0;
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (r_base >= r_n) begin
                        r_base <= r_base - r_n;
                    end else begin
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_k     <= '0;
                    r_xc    <= r_base[fconv_pkg::SMP_AW-1:0];
                    r_xz    <= fconv_pkg::POS_W'(r_i) + fconv_pkg::POS_W'(i_cfg.tap_offset);
                    r_acc   <= '0;
                    r_state <= (tc == '0) ? S_DRAIN : S_ISSUE;
                end
                S_ISSUE: begin
                    r_k  <= r_k + fconv_pkg::TC_W'(1);
                    r_xz <= r_xz - fconv_pkg::POS_W'(1);
                    if (r_xc == '0) begin
                        r_xc <= fconv_pkg::SMP_AW'(r_n - fconv_pkg::CNT_W'(1));
                    end else begin
                        r_xc <= r_xc - fconv_pkg::SMP_AW'(1);
                    end
                    if ((r_k + fconv_pkg::TC_W'(1)) == tc) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_p1_vld && !r_p2_vld) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (!i_res_full) begin
                        if (is_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= r_i + fconv_pkg::SMP_AW'(1);
                            r_base  <= ((r_base + fconv_pkg::CNT_W'(1)) == r_n)
                                     ? '0 : r_base + fconv_pkg::CNT_W'(1);
                            r_state <= S_START;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_write_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> (!r_p1_vld && !r_p2_vld))
        else $error("result taken before accumulation finished");

    a_wrap_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ISSUE) |-> (fconv_pkg::CNT_W'(r_xc) < r_n))
        else $error("circular position outside frame");

    a_pipe_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p2_vld |-> $past(r_p1_vld))
        else $error("product without read");

    a_no_cmd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == S_IDLE))
        else $error("item taken while frame busy");
`endif

endmodule

// ===== rtl/core/frame_convolution_wrap_or_zero_core.sv =====
// channel  | handshake          | payload
// ---------+--------------------+-------------------------------------------
// input    | push / full        | i_mode, i_tap_index, i_value, i_last
// result   | empty / pop        | o_result, o_last_result
// config   | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// tap writes and non-closing samples are stored by the back end as it takes them
// a closing sample first reduces tap_offset modulo the frame length, then each result
// is formed tap by tap in the single multiply-accumulate unit, drained and written
// results wait in a two-deep queue, items in a two-deep queue ahead of the back end
// i_rst_n is synchronous; kernel and sample memories are not cleared
module frame_convolution_wrap_or_zero_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic                                  i_mode,
    input  logic [fconv_pkg::TAP_AW-1:0]          i_tap_index,
    input  logic signed [fconv_pkg::SAMPLE_WIDTH-1:0] i_value,
    input  logic                                  i_last,
    output logic                                  empty,
    input  logic                                  pop,
    output logic signed [fconv_pkg::RES_W-1:0]    o_result,
    output logic                                  o_last_result,
    input  logic                                  i_cfg_we,
    input  logic [fconv_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [fconv_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    fconv_pkg::t_cfg r_cfg;
    fconv_pkg::t_cmd front_cmd;
    fconv_pkg::t_cmd q_cmd;
    fconv_pkg::t_res back_res;
    fconv_pkg::t_res out_res;
    logic            front_push;
    logic            q_vld;
    logic            q_pop;
    logic            res_full;
    logic            res_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tap_count  <= fconv_pkg::TC_W'(1);
            r_cfg.tap_offset <= '0;
            r_cfg.circular   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (fconv_pkg::t_cfg_idx'(i_cfg_idx))
                fconv_pkg::CFG_TAP_COUNT:  r_cfg.tap_count  <= i_cfg_data[fconv_pkg::TC_W-1:0];
                fconv_pkg::CFG_TAP_OFFSET: r_cfg.tap_offset <= i_cfg_data[fconv_pkg::OFF_W-1:0];
                fconv_pkg::CFG_CIRCULAR:   r_cfg.circular   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    fconv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_full      (full),
        .i_mode      (i_mode),
        .i_tap_index (i_tap_index),
        .i_value     (i_value),
        .i_last      (i_last),
        .o_cmd_push  (front_push),
        .o_cmd       (front_cmd)
    );

    fconv_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_vld   (q_vld),
        .o_data  (q_cmd)
    );

    fconv_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cmd_vld  (q_vld),
        .i_cmd      (q_cmd),
        .o_cmd_pop  (q_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res      (back_res)
    );

    fconv_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (out_res)
    );

    assign o_result      = out_res.result;
    assign o_last_result = out_res.last;

endmodule

// ===== test/frame_conv_checker.sv =====
module frame_conv_checker (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      push,
    input  logic                                      full,
    input  logic                                      i_mode,
    input  logic [fconv_pkg::TAP_AW-1:0]              i_tap_index,
    input  logic signed [fconv_pkg::SAMPLE_WIDTH-1:0] i_value,
    input  logic                                      i_last,
    input  logic                                      empty,
    input  logic                                      pop,
    input  logic signed [fconv_pkg::RES_W-1:0]        o_result,
    input  logic                                      o_last_result,
    input  logic                                      i_cfg_we,
    input  logic [fconv_pkg::CFG_IDX_W-1:0]           i_cfg_idx,
    input  logic [fconv_pkg::CFG_DATA_W-1:0]          i_cfg_data,
    output int                                        o_mismatches,
    output int                                        o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import fconv_pkg::*;

    logic [TC_W-1:0]                tap_count_q = TC_W'(1);
    logic [OFF_W-1:0]               tap_offset_q = '0;
    logic                           circular_q = 0;
    logic signed [SAMPLE_WIDTH-1:0] kernel_coef [MAX_TAPS];
    logic signed [SAMPLE_WIDTH-1:0] frame_buf [MAX_SAMPLES];
    int                             frame_len = 0;
    t_res                           pending_outputs [$];
    int                             mismatches = 0;

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    // one output sample: kernel tap tap_offset placed on pos, outside positions wrap or read as zero
    function automatic logic signed [RES_W-1:0] conv_output(int pos, int len);
        int     taps;
        int     origin;
        int     j;
        int     x;
        longint acc;
        taps   = (tap_count_q > MAX_TAPS) ? MAX_TAPS : int'(tap_count_q);
        origin = int'(tap_offset_q);
        acc    = 0;
        for (j = -origin; j < taps - origin; j++) begin
            x = pos - j;
            if (circular_q) begin
                x = x % len;
                if (x < 0)
                    x += len;
            end
            if (x >= 0 && x < len)
                acc += longint'(kernel_coef[TAP_AW'(j + origin)]) *
                       longint'(frame_buf[SMP_AW'(x)]);
        end
        acc = acc >>> (SAMPLE_WIDTH - 1);
        if (acc > 64'sd2147483647)
            acc = 64'sd2147483647;
        else if (acc < -64'sd2147483648)
            acc = -64'sd2147483648;
        return RES_W'(acc);
    endfunction

    task automatic log_mismatch(string why, t_res want, t_res got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: %s: expected result %0d last %0b, got result %0d last %0b",
                     $time, why, $signed(want.result), want.last,
                     $signed(got.result), got.last);
    endtask

    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        int   n;
        if (!i_rst_n) begin
            tap_count_q  = TC_W'(1);
            tap_offset_q = '0;
            circular_q   = 1'b0;
            frame_len    = 0;
            pending_outputs.delete();
        end else begin
            if (pop && !empty) begin
                got.result = o_result;
                got.last   = o_last_result;
                if (pending_outputs.size() == 0) begin
                    want = '0;
                    log_mismatch("output with nothing expected", want, got);
                end else begin
                    want = pending_outputs.pop_front();
                    if (got.result !== want.result || got.last !== want.last)
                        log_mismatch("output mismatch", want, got);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TAP_COUNT:  tap_count_q  = i_cfg_data[TC_W-1:0];
                    CFG_TAP_OFFSET: tap_offset_q = i_cfg_data[OFF_W-1:0];
                    CFG_CIRCULAR:   circular_q   = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (push && !full) begin
                if (!i_mode) begin
                    kernel_coef[i_tap_index] = i_value;
                end else begin
                    // samples past a full frame are dropped, last still closes it
                    if (frame_len < MAX_SAMPLES) begin
                        frame_buf[SMP_AW'(frame_len)] = i_value;
                        frame_len++;
                    end
                    if (i_last) begin
                        for (n = 0; n < frame_len; n++)
                            pending_outputs.push_back(
                                t_res'{conv_output(n, frame_len), n == frame_len - 1});
                        frame_len = 0;
                    end
                end
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= pending_outputs.size();
    end

endmodule

// ===== test/frame_convolution_wrap_or_zero_core_test.sv =====
module frame_convolution_wrap_or_zero_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import fconv_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int LONG_HOLD    = 400;
    localparam int RANDOM_ITEMS = 240;
    localparam int SETTLE       = 20;
    localparam logic signed [SAMPLE_WIDTH-1:0] ALT_PATTERN [5] = '{
        16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh0001
    };

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           push = 1'b0;
    logic                           full;
    logic                           i_mode = 1'b0;
    logic [TAP_AW-1:0]              i_tap_index = '0;
    logic signed [SAMPLE_WIDTH-1:0] i_value = '0;
    logic                           i_last = 1'b0;
    logic                           empty;
    logic                           pop = 1'b0;
    logic signed [RES_W-1:0]        o_result;
    logic                           o_last_result;
    logic                           i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]           i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]          i_cfg_data = '0;

    int   mismatches;
    int   outstanding;
    int   idle_cycles = 0;
    int   items_offered = 0;
    bit   tx_high = 1'b0;
    bit   tx_gaps = 1'b0;
    logic rx_gaps = 1'b0;
    logic hold_results = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    frame_convolution_wrap_or_zero_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_mode        (i_mode),
        .i_tap_index   (i_tap_index),
        .i_value       (i_value),
        .i_last        (i_last),
        .empty         (empty),
        .pop           (pop),
        .o_result      (o_result),
        .o_last_result (o_last_result),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    frame_conv_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_mode        (i_mode),
        .i_tap_index   (i_tap_index),
        .i_value       (i_value),
        .i_last        (i_last),
        .empty         (empty),
        .pop           (pop),
        .o_result      (o_result),
        .o_last_result (o_last_result),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 8);
        if (r < 95)
            return $urandom_range(9, 32);
        return $urandom_range(60, 70);
    endfunction

    task automatic offer(input logic mode, input logic [TAP_AW-1:0] idx,
                         input logic signed [SAMPLE_WIDTH-1:0] val, input logic fin);
        push        <= 1'b1;
        i_mode      <= mode;
        i_tap_index <= idx;
        i_value     <= val;
        i_last      <= fin;
        tx_high      = 1'b1;
        do
            @(posedge i_clk);
        while (full);
        items_offered++;
    endtask

    task automatic tx_pause();
        int n;
        n = tx_gaps ? pick_gap() : 0;
        if (n > 0) begin
            push    <= 1'b0;
            tx_high  = 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic put_tap(input logic [TAP_AW-1:0] idx, input logic signed [SAMPLE_WIDTH-1:0] val);
        offer(1'b0, idx, val, 1'($urandom_range(0, 1)));
        tx_pause();
    endtask

    task automatic put_frame(input int len);
        int s;
        for (s = 0; s < len; s++) begin
            if ($urandom_range(0, 99) < 12)
                put_tap(TAP_AW'($urandom), pick_value());
            offer(1'b1, TAP_AW'($urandom), pick_value(), s == len - 1);
            tx_pause();
        end
    endtask

    // stop sending and wait until every output has been taken
    task automatic drain();
        if (tx_high)
            push <= 1'b0;
        tx_high = 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic configure(input logic [TC_W-1:0] taps, input logic [OFF_W-1:0] origin,
                             input logic wrap);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_TAP_COUNT;
        i_cfg_data <= CFG_DATA_W'(taps);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_TAP_OFFSET;
        i_cfg_data <= CFG_DATA_W'(origin);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_CIRCULAR;
        i_cfg_data <= CFG_DATA_W'(wrap);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin : receiver
        int gap;
        bit held;
        gap  = 0;
        held = 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_results && !held) begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                gap = 0;
            end else begin
                if (pop && !empty)
                    gap = rx_gaps ? pick_gap() : 0;
                else if (!pop && gap > 0)
                    gap--;
                pop <= (gap == 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : stimulus
        int                k;
        int                phase;
        int                frames;
        int                base;
        int                span;
        logic [TC_W-1:0]   taps;
        logic [OFF_W-1:0]  origin;
        logic              wrap;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full kernel load so no unwritten tap is ever read
        for (k = 0; k < MAX_TAPS; k++)
            offer(1'b0, TAP_AW'(k), (k == 0) ? 16'sh7FFF : (k == 1) ? 16'sh8000 : pick_value(),
                  k[0]);

        // reset config: single tap, no offset, zero padding
        offer(1'b1, 6'd0, 16'sh8000, 1'b0);
        offer(1'b1, 6'd63, 16'sh7FFF, 1'b0);
        offer(1'b1, 6'd0, 16'sh0000, 1'b0);
        offer(1'b1, 6'd0, 16'shFFFF, 1'b1);
        drain();

        configure(7'd3, 6'd1, 1'b0);
        for (k = 0; k < 5; k++)
            offer(1'b1, TAP_AW'(k), ALT_PATTERN[3'(k)], k == 4);
        drain();

        configure(7'd3, 6'd1, 1'b1);
        for (k = 0; k < 5; k++)
            offer(1'b1, TAP_AW'(k), ALT_PATTERN[3'(k)], k == 4);
        drain();

        // zero tap count
        configure(7'd0, 6'd5, 1'b1);
        for (k = 0; k < 3; k++)
            offer(1'b1, TAP_AW'(k), pick_value(), k == 2);
        drain();

        // tap count saturates, origin at the far end
        configure(7'd127, 6'd63, 1'b1);
        offer(1'b1, 6'd0, 16'sh7FFF, 1'b0);
        offer(1'b1, 6'd0, 16'sh8000, 1'b1);
        drain();

        // origin outside the kernel, single-sample frame
        configure(7'd4, 6'd10, 1'b0);
        offer(1'b1, 6'd0, 16'sh4000, 1'b1);
        drain();

        base  = items_offered;
        phase = 0;
        while (items_offered - base < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       taps = 7'd0;
                1:       taps = 7'd127;
                2:       taps = 7'd64;
                3:       taps = 7'd1;
                default: taps = TC_W'($urandom_range(1, 16));
            endcase
            span = (taps == 0) ? 1 : (taps > MAX_TAPS) ? MAX_TAPS : int'(taps);
            case ($urandom_range(0, 5))
                0:       origin = 6'd0;
                1:       origin = 6'd63;
                2:       origin = OFF_W'($urandom_range(0, 63));
                default: origin = OFF_W'($urandom_range(0, span - 1));
            endcase
            wrap = 1'($urandom_range(0, 1));
            configure(taps, origin, wrap);

            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_gaps <= ($urandom_range(0, 3) != 0);
            frames  = $urandom_range(2, 6);
            if (phase == 1) begin
                // results held back while items keep coming
                hold_results <= 1'b1;
                tx_gaps       = 1'b0;
                frames        = 8;
            end
            for (k = 0; k < frames; k++)
                put_frame((phase == 0 && k == 0) ? 68 : pick_len());
            drain();
            phase++;
        end

        repeat (200) @(posedge i_clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
